// ===== sv/varint_stream_decoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// varint_stream_decoder_unit_assert.svh
// Assertion macros used by the checker file of the varint decoder.
// ----------------------------------------------------------------------------
`ifndef VARINT_STREAM_DECODER_UNIT_ASSERT_SVH
`define VARINT_STREAM_DECODER_UNIT_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define VSD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A stalled transfer keeps valid high and its payload steady on the next edge.
`define VSD_ASSERT_HOLD(label, vld, rdy, pay, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && !(rdy)) |=> ((vld) && $stable(pay))) \
		else $error(msg);

`endif

// ===== sv/vsd_pkg.sv =====
// ----------------------------------------------------------------------------
// vsd_pkg
// Types and constants of the varint stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vsd_pkg;

	localparam int BYTE_W      = 8;
	localparam int DIGIT_W     = 7;
	localparam int VALUE_W     = 64;
	localparam int COUNT_W     = 4;
	localparam int STATUS_W    = 2;
	localparam int MAX_BYTES   = 10;
	localparam int LAST_POS    = MAX_BYTES - 1;
	localparam int SHIFT_W     = 6;
	localparam int HALF_W      = 32;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_TRUNCATED = 2'd2,
		ST_EXCEEDS32 = 2'd3
	} vsd_status_t;

	// What the back end must do with one byte
	typedef enum logic [1:0] {
		KIND_CONT,
		KIND_TERM,
		KIND_OVF,
		KIND_TRUNC
	} vsd_kind_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic [COUNT_W-1:0] pos;
		vsd_kind_t          kind;
	} vsd_entry_t;

	// Register word indexes on the configuration port
	typedef enum logic [0:0] {
		REG_MODE_32BIT = 1'b0,
		REG_NONE       = 1'b1
	} vsd_reg_t;

endpackage

`default_nettype wire

// ===== sv/vsd_if.sv =====
// ----------------------------------------------------------------------------
// vsd_byte_if / vsd_result_if
// Valid/ready channels for stream bytes and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface vsd_byte_if;
	logic                        valid;
	logic                        ready;
	logic [vsd_pkg::BYTE_W-1:0]  data_byte;
	logic                        buffer_end;

	modport source(output valid, data_byte, buffer_end, input ready);
	modport sink(input valid, data_byte, buffer_end, output ready);
endinterface

interface vsd_result_if;
	logic                         valid;
	logic                         ready;
	logic [vsd_pkg::VALUE_W-1:0]  value;
	logic [vsd_pkg::COUNT_W-1:0]  byte_count;
	logic [vsd_pkg::STATUS_W-1:0] status;

	modport source(output valid, value, byte_count, status, input ready);
	modport sink(input valid, value, byte_count, status, output ready);
endinterface

`default_nettype wire

// ===== sv/vsd_front.sv =====
// ----------------------------------------------------------------------------
// vsd_front
// Accepts stream bytes, tracks the byte position and classifies each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module vsd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	vsd_byte_if.sink              stream,
	input  wire logic             q_full,
	output logic                  push,
	output vsd_pkg::vsd_entry_t   entry
);

	logic [vsd_pkg::COUNT_W-1:0] pos_q;
	logic                        at_last;
	logic                        digit_big;

	assign stream.ready = !q_full;
	assign push         = stream.valid && !q_full;

	assign at_last   = (pos_q == vsd_pkg::COUNT_W'(vsd_pkg::LAST_POS));
	assign digit_big = (stream.data_byte[vsd_pkg::DIGIT_W-1:0] > vsd_pkg::DIGIT_W'(1));

	always_comb begin
		entry.digit = stream.data_byte[vsd_pkg::DIGIT_W-1:0];
		entry.pos   = pos_q;
		if (!stream.data_byte[vsd_pkg::BYTE_W-1]) begin
			entry.kind = (at_last && digit_big) ? vsd_pkg::KIND_OVF : vsd_pkg::KIND_TERM;
		end else if (at_last) begin
			// overflow wins over buffer end
			entry.kind = vsd_pkg::KIND_OVF;
		end else if (stream.buffer_end) begin
			entry.kind = vsd_pkg::KIND_TRUNC;
		end else begin
			entry.kind = vsd_pkg::KIND_CONT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			// advance on a continuation byte, restart after any result
			pos_q <= (entry.kind == vsd_pkg::KIND_CONT) ? pos_q + 1'b1 : '0;
		end
	end

endmodule

`default_nettype wire

// ===== sv/vsd_queue.sv =====
// ----------------------------------------------------------------------------
// vsd_queue
// Two-entry queue of classified bytes between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vsd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  vsd_pkg::vsd_entry_t wr_entry,
	output logic                full,
	output logic                q_valid,
	input  wire logic           pop,
	output vsd_pkg::vsd_entry_t rd_entry
);

	vsd_pkg::vsd_entry_t             mem_q [vsd_pkg::QUEUE_DEPTH];
	logic [vsd_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [vsd_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [vsd_pkg::QUEUE_CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == vsd_pkg::QUEUE_CNT_W'(vsd_pkg::QUEUE_DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/vsd_back.sv =====
// ----------------------------------------------------------------------------
// vsd_back
// Merges digits into the accumulator and registers finished results.
// ----------------------------------------------------------------------------
`default_nettype none

module vsd_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           mode_32bit,
	input  wire logic           q_valid,
	input  vsd_pkg::vsd_entry_t entry,
	output logic                pop,
	vsd_result_if.source        result
);

	logic [vsd_pkg::VALUE_W-1:0]  acc_q;
	logic [vsd_pkg::VALUE_W-1:0]  value_q;
	logic [vsd_pkg::COUNT_W-1:0]  count_q;
	vsd_pkg::vsd_status_t         status_q;
	logic                         out_valid_q;

	logic [vsd_pkg::SHIFT_W-1:0]  shamt;
	logic [vsd_pkg::VALUE_W-1:0]  merged;
	logic                         exceeds;
	logic                         emit;

	// digit weight is 7 * position; digit bits past bit 63 fall off
	assign shamt   = vsd_pkg::SHIFT_W'(entry.pos) * vsd_pkg::SHIFT_W'(vsd_pkg::DIGIT_W);
	assign merged  = acc_q | ({{(vsd_pkg::VALUE_W-vsd_pkg::DIGIT_W){1'b0}}, entry.digit} << shamt);
	assign exceeds = (merged[vsd_pkg::VALUE_W-1:vsd_pkg::HALF_W] != '0);

	assign pop  = q_valid && (!out_valid_q || result.ready);
	assign emit = pop && (entry.kind != vsd_pkg::KIND_CONT);

	assign result.valid      = out_valid_q;
	assign result.value      = value_q;
	assign result.byte_count = count_q;
	assign result.status     = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q <= (entry.kind == vsd_pkg::KIND_CONT) ? merged : '0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			case (entry.kind)
				vsd_pkg::KIND_TERM: begin
					if (mode_32bit && exceeds) begin
						value_q  <= '0;
						count_q  <= '0;
						status_q <= vsd_pkg::ST_EXCEEDS32;
					end else begin
						value_q  <= merged;
						count_q  <= entry.pos + 1'b1;
						status_q <= vsd_pkg::ST_OK;
					end
				end
				vsd_pkg::KIND_TRUNC: begin
					value_q  <= '0;
					count_q  <= '0;
					status_q <= vsd_pkg::ST_TRUNCATED;
				end
				default: begin
					value_q  <= '0;
					count_q  <= '0;
					status_q <= vsd_pkg::ST_OVERFLOW;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/varint_stream_decoder_unit.sv =====
// Path: the queue stores each byte; the back end pops it and registers any result.
// Throughput: one byte per cycle, set by the back end taking one queue entry a cycle.
// A result waiting at the output holds the back end; the queue takes up to two
// bytes before the input stalls.
// Reset: arst_n asynchronously clears the position, queue, accumulator,
// output valid and mode_32bit; no clearing pass is needed.
// ----------------------------------------------------------------------------
// varint_stream_decoder_unit
// Unsigned LEB128 decoder, 64-bit, with an APB register for 32-bit mode.
// ----------------------------------------------------------------------------
`default_nettype none

module varint_stream_decoder_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	vsd_byte_if.sink                               stream,
	vsd_result_if.source                           result,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [vsd_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [vsd_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [vsd_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                   pready
);

	logic                 mode_32bit_q;
	logic                 push;
	logic                 pop;
	logic                 q_full;
	logic                 q_valid;
	vsd_pkg::vsd_entry_t  wr_entry;
	vsd_pkg::vsd_entry_t  rd_entry;
	logic                 reg_sel;
	logic                 cfg_write;

	assign pready    = 1'b1;
	assign reg_sel   = (paddr[vsd_pkg::APB_ADDR_W-1] == vsd_pkg::REG_MODE_32BIT);
	assign cfg_write = psel && penable && pwrite && pready && reg_sel;
	assign prdata    = reg_sel ? {{(vsd_pkg::APB_DATA_W-1){1'b0}}, mode_32bit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_32bit_q <= 1'b0;
		end else if (cfg_write) begin
			mode_32bit_q <= pwdata[0];
		end
	end

	vsd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.q_full (q_full),
		.push   (push),
		.entry  (wr_entry)
	);

	vsd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.q_valid  (q_valid),
		.pop      (pop),
		.rd_entry (rd_entry)
	);

	vsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_32bit (mode_32bit_q),
		.q_valid    (q_valid),
		.entry      (rd_entry),
		.pop        (pop),
		.result     (result)
	);

endmodule

`default_nettype wire

// ===== sv/vsd_checker.sv =====
// ----------------------------------------------------------------------------
// vsd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "varint_stream_decoder_unit_assert.svh"

module vsd_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          res_valid,
	input wire logic                          res_ready,
	input wire logic [vsd_pkg::VALUE_W-1:0]   res_value,
	input wire logic [vsd_pkg::COUNT_W-1:0]   res_count,
	input wire logic [vsd_pkg::STATUS_W-1:0]  res_status
);

	logic status_ok;
	logic count_in_range;

	assign status_ok      = (res_status == vsd_pkg::ST_OK);
	assign count_in_range = (res_count != '0) &&
		(res_count <= vsd_pkg::COUNT_W'(vsd_pkg::MAX_BYTES));

	`VSD_ASSERT_HOLD(a_result_hold, res_valid, res_ready, {res_value, res_count, res_status}, "result changed while stalled")
	`VSD_ASSERT_IMPL(a_error_zero, res_valid && !status_ok, (res_value == '0) && (res_count == '0), "error result with nonzero value or count")
	`VSD_ASSERT_IMPL(a_ok_count, res_valid && status_ok, count_in_range, "ok result with byte count out of range")
	`VSD_ASSERT_IMPL(a_single_byte, res_valid && status_ok && (res_count == 4'd1), (res_value[vsd_pkg::VALUE_W-1:vsd_pkg::DIGIT_W] == '0), "one-byte value wider than seven bits")

endmodule

bind varint_stream_decoder_unit vsd_checker u_vsd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_value  (result.value),
	.res_count  (result.byte_count),
	.res_status (result.status)
);

`default_nettype wire
